FILE: hdl/vmt_pkg.sv
// shared constants and types for the vertex matrix transform
// no dependencies; imported by the interfaces, the top level, the checker and the testbench
package vmt_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MAT_DIM    = 4;
   localparam int IDX_W      = $clog2(MAT_DIM);
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int PAIR_W     = PROD_W + 1;
   localparam int SUM_W      = PROD_W + 2;

   // request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_XFORM = 1'b1;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [PAIR_W-1:0]     pair_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic [IDX_W-1:0]             idx_type;

   localparam data_type ONE_VALUE = data_type'(64'd1 << FRAC_BITS);
   localparam data_type SAT_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type SAT_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

endpackage

FILE: hdl/vmt_if.sv
// request and response channel interfaces of the vertex matrix transform
// depends on vmt_pkg
interface vmt_req_if import vmt_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     func;
   idx_type  mat_row;
   idx_type  mat_col;
   data_type elem_value;
   data_type vec_x;
   data_type vec_y;
   data_type vec_z;
   data_type vec_w;

   modport source (output valid, func, mat_row, mat_col, elem_value,
                   output vec_x, vec_y, vec_z, vec_w, input ready);
   modport sink (input valid, func, mat_row, mat_col, elem_value,
                 input vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

interface vmt_rsp_if import vmt_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type out_x;
   data_type out_y;
   data_type out_z;
   data_type out_w;

   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

FILE: hdl/vertex_matrix_transform.sv
// vertex matrix transform top level: 4x4 matrix store and three-stage pipeline
// depends on vmt_pkg and the channel interfaces in vmt_if.sv
//
// multiplies a signed q16.16 row vector (x,y,z,w) by a stored 4x4 matrix,
// out[i] = sum over k of v[k]*m[k][i]. a request with func = write stores
// elem_value at (mat_row, mat_col) and gives no response; a request with
// func = transform gives one response. the matrix is identity after reset.
// the pipeline takes one request per clock while req.ready is high; a
// transform's response shows rsp.valid once through the stage registers:
// stage 1 forms the sixteen 32x32 products, stage 2 adds them in pairs,
// stage 3 completes each column sum, shifts it right by the fraction width
// (rounding toward minus infinity) and saturates it to 32 bits. a write
// affects every transform accepted after it. when the response side stalls
// the stages fill up and req.ready drops only once all three hold a transform
module vertex_matrix_transform import vmt_pkg::*; (
   input logic       clock,
   input logic       reset,
   vmt_req_if.sink   req,
   vmt_rsp_if.source rsp
);

   // matrix store, row major
   data_type matrix_ff [MAT_DIM][MAT_DIM];

   // stage valid bits
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   // stage payloads
   prod_type s1_prod_in [MAT_DIM][MAT_DIM];
   prod_type s1_prod_ff [MAT_DIM][MAT_DIM];
   pair_type s2_pair_in [MAT_DIM][2];
   pair_type s2_pair_ff [MAT_DIM][2];
   data_type s3_out_in  [MAT_DIM];
   data_type s3_out_ff  [MAT_DIM];

   data_type vec [MAT_DIM];
   logic     req_fire;
   logic     xform_fire;
   logic     write_fire;

   // a stage moves on when it is empty or its successor takes its contents
   assign s3_ready  = !s3_valid_ff || rsp.ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;

   assign req_fire   = req.valid && req.ready;
   assign xform_fire = req_fire && (req.func == FUNC_XFORM);
   assign write_fire = req_fire && (req.func == FUNC_WRITE);

   assign vec[0] = req.vec_x;
   assign vec[1] = req.vec_y;
   assign vec[2] = req.vec_z;
   assign vec[3] = req.vec_w;

   // matrix element writes, identity on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAT_DIM; r++) begin
            for (int c = 0; c < MAT_DIM; c++) begin
               matrix_ff[r][c] <= (r == c) ? ONE_VALUE : '0;
            end
         end
      end else if (write_fire) begin
         matrix_ff[req.mat_row][req.mat_col] <= req.elem_value;
      end
   end

   // stage 1: one full product per matrix element
   always_comb begin
      for (int k = 0; k < MAT_DIM; k++) begin
         for (int i = 0; i < MAT_DIM; i++) begin
            s1_prod_in[k][i] = vec[k] * matrix_ff[k][i];
         end
      end
   end

   // stage 2: pairwise sums per output component
   always_comb begin
      for (int i = 0; i < MAT_DIM; i++) begin
         s2_pair_in[i][0] = pair_type'(s1_prod_ff[0][i]) + pair_type'(s1_prod_ff[1][i]);
         s2_pair_in[i][1] = pair_type'(s1_prod_ff[2][i]) + pair_type'(s1_prod_ff[3][i]);
      end
   end

   // stage 3: final sum, floor shift and saturation
   always_comb begin
      sum_type total;
      sum_type shifted;
      logic [SUM_W-DATA_WIDTH:0] upper;
      for (int i = 0; i < MAT_DIM; i++) begin
         total   = sum_type'(s2_pair_ff[i][0]) + sum_type'(s2_pair_ff[i][1]);
         shifted = total >>> FRAC_BITS;
         upper   = shifted[SUM_W-1:DATA_WIDTH-1];
         if ((&upper) || !(|upper)) begin
            s3_out_in[i] = shifted[DATA_WIDTH-1:0];
         end else if (total[SUM_W-1]) begin
            s3_out_in[i] = SAT_MIN;
         end else begin
            s3_out_in[i] = SAT_MAX;
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= xform_fire;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload registers, loaded only when the stage advances with data
   always_ff @(posedge clock) begin
      if (s1_ready && xform_fire) begin
         s1_prod_ff <= s1_prod_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_pair_ff <= s2_pair_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_out_ff <= s3_out_in;
      end
   end

   assign rsp.valid = s3_valid_ff;
   assign rsp.out_x = s3_out_ff[0];
   assign rsp.out_y = s3_out_ff[1];
   assign rsp.out_z = s3_out_ff[2];
   assign rsp.out_w = s3_out_ff[3];

endmodule

FILE: hdl/vmt_checker.sv
// port-level checker for the vertex matrix transform, bound to the top level
// depends on vmt_pkg and vertex_matrix_transform
module vmt_checker import vmt_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     req_func,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input data_type rsp_out_x,
   input data_type rsp_out_w
);

   localparam logic [2:0] PIPE_DEPTH = 3'd3;

   // transforms accepted and not yet delivered
   logic [2:0] pending_ff, pending_in;
   logic       xform_acc, rsp_acc;

   assign xform_acc = req_valid && req_ready && (req_func == FUNC_XFORM);
   assign rsp_acc   = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (xform_acc && !rsp_acc) begin
         pending_in = pending_ff + 3'd1;
      end else if (!xform_acc && rsp_acc) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response stays valid with out_x and out_w unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_w))
      else $error("response changed while stalled");

   // reset empties the pipeline
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // no response without an outstanding transform
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without a transform request");

   // a full, stalled pipeline takes nothing more
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && pending_ff == PIPE_DEPTH |-> !req_ready)
      else $error("request taken with the pipeline full");

endmodule

bind vertex_matrix_transform vmt_checker u_vmt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_func  (req.func),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_out_x (rsp.out_x),
   .rsp_out_w (rsp.out_w)
);

FILE: dv/vertex_matrix_transform_tb.sv
// self-checking testbench for the vertex matrix transform
// depends on vmt_pkg, the channel interfaces in vmt_if.sv and the top level
module vertex_matrix_transform_tb import vmt_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 4;
   localparam int ITEM_TARGET    = 1450;
   localparam int RESULT_LATENCY = 3;
   localparam int HOLD_CYCLES    = 300;
   localparam int CYCLE_LIMIT    = 500000;

   typedef struct {
      data_type comp [MAT_DIM];
   } vertex_type;

   // shadow of the matrix store plus the queue of vertices still owed by the block
   class xform_scoreboard;
      data_type   matrix [MAT_DIM*MAT_DIM];
      vertex_type owed_vertices [$];
      int         errors;
      int         writes;
      int         xforms;
      int         responses;
      int         saturations;

      function new();
         foreach (matrix[i]) matrix[i] = (i % (MAT_DIM + 1) == 0) ? ONE_VALUE : '0;
      endfunction

      // row vector times matrix, full precision, floor shift, saturate
      function vertex_type project_vertex(vertex_type vin);
         vertex_type vout;
         sum_type    acc;
         sum_type    shifted;
         for (int i = 0; i < MAT_DIM; i++) begin
            acc = '0;
            for (int k = 0; k < MAT_DIM; k++) begin
               acc += sum_type'(vin.comp[k]) * sum_type'(matrix[k*MAT_DIM + i]);
            end
            shifted = acc >>> FRAC_BITS;
            if (shifted > sum_type'(SAT_MAX)) begin
               vout.comp[i] = SAT_MAX;
               saturations++;
            end else if (shifted < sum_type'(SAT_MIN)) begin
               vout.comp[i] = SAT_MIN;
               saturations++;
            end else begin
               vout.comp[i] = data_type'(shifted);
            end
         end
         return vout;
      endfunction

      function void note_request(logic func, idx_type row, idx_type col, data_type elem,
                                 vertex_type vin);
         if (func == FUNC_WRITE) begin
            matrix[{row, col}] = elem;
            writes++;
         end else begin
            owed_vertices.push_back(project_vertex(vin));
            xforms++;
         end
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_response(vertex_type got);
         vertex_type want;
         string      axis [MAT_DIM] = '{"x", "y", "z", "w"};
         responses++;
         if (owed_vertices.size() == 0) begin
            report("response with no transform outstanding");
         end else begin
            want = owed_vertices.pop_front();
            for (int i = 0; i < MAT_DIM; i++) begin
               if (got.comp[i] !== want.comp[i])
                  report($sformatf("out_%s got %h want %h (response %0d)", axis[i],
                                   got.comp[i], want.comp[i], responses));
            end
         end
      endtask

      function int outstanding();
         return owed_vertices.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   vmt_req_if req_bus ();
   vmt_rsp_if rsp_bus ();

   vertex_matrix_transform uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   xform_scoreboard sb;
   int issued;
   int send_idle_pct;
   int blocked_cycles;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // watchdog: anything that hangs ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transforms outstanding", cycle_count,
                  sb.outstanding());
         $display("vertex_matrix_transform_tb: errors");
         $finish;
      end
   end

   // both channels sampled at the rising edge, before the block updates them
   always @(posedge clock) begin : watch_channels
      vertex_type vin;
      vertex_type got;
      if (!reset && req_bus.valid && req_bus.ready) begin
         vin.comp[0] = req_bus.vec_x;
         vin.comp[1] = req_bus.vec_y;
         vin.comp[2] = req_bus.vec_z;
         vin.comp[3] = req_bus.vec_w;
         sb.note_request(req_bus.func, req_bus.mat_row, req_bus.mat_col,
                         req_bus.elem_value, vin);
      end
      if (!reset && req_bus.valid && !req_bus.ready)
         blocked_cycles++;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.comp[0] = rsp_bus.out_x;
         got.comp[1] = rsp_bus.out_y;
         got.comp[2] = rsp_bus.out_z;
         got.comp[3] = rsp_bus.out_w;
         sb.check_response(got);
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // q16.16 value biased towards the corners and towards modest magnitudes
   function automatic data_type rand_value();
      int t;
      case ($urandom_range(0, 15))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return '0;
         3: return ONE_VALUE;
         4: return data_type'(-ONE_VALUE);
         5, 6, 7: return data_type'($urandom());
         default: begin
            t = $urandom_range(0, 1 << 23);
            return data_type'(t - (1 << 22));
         end
      endcase
   endfunction

   // matrix entries mostly within +-2.0 so that results do not all saturate
   function automatic data_type rand_elem();
      int t;
      if ($urandom_range(0, 9) == 0)
         return rand_value();
      t = $urandom_range(0, 1 << 18);
      return data_type'(t - (1 << 17));
   endfunction

   function automatic vertex_type rand_vertex();
      vertex_type v;
      foreach (v.comp[i]) v.comp[i] = rand_value();
      return v;
   endfunction

   function automatic vertex_type make_vertex(data_type x, data_type y,
                                              data_type z, data_type w);
      vertex_type v;
      v.comp[0] = x;
      v.comp[1] = y;
      v.comp[2] = z;
      v.comp[3] = w;
      return v;
   endfunction

   // present one request and hold it until the block takes it
   task automatic send_request(logic func, idx_type row, idx_type col, data_type elem,
                               vertex_type v);
      int gap;
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.func       <= func;
      req_bus.mat_row    <= row;
      req_bus.mat_col    <= col;
      req_bus.elem_value <= elem;
      req_bus.vec_x      <= v.comp[0];
      req_bus.vec_y      <= v.comp[1];
      req_bus.vec_z      <= v.comp[2];
      req_bus.vec_w      <= v.comp[3];
      do @(posedge clock); while (!req_bus.ready);
      issued++;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // vector fields are don't-care on a write, so fill them with noise
   task automatic send_write(idx_type row, idx_type col, data_type elem);
      send_request(FUNC_WRITE, row, col, elem, rand_vertex());
   endtask

   // element fields are don't-care on a transform
   task automatic send_xform(vertex_type v);
      send_request(FUNC_XFORM, idx_type'($urandom()), idx_type'($urandom()),
                   data_type'($urandom()), v);
   endtask

   // response side: random stalls in shifting densities, plus two long hold-offs
   initial begin : drive_response_ready
      int stall_left;
      int stall_pct;
      int phase_cycles;
      int hold_points [$];
      rsp_bus.ready = 1'b0;
      stall_left    = 0;
      stall_pct     = 0;
      phase_cycles  = 0;
      hold_points   = '{200, 800};
      @(negedge reset);
      forever begin
         @(negedge clock);
         phase_cycles++;
         if (phase_cycles % 150 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 15;
               default: stall_pct = 45;
            endcase
         end
         if (hold_points.size() != 0 && sb.responses >= hold_points[0]) begin
            // long back-pressure: the pipeline fills and req.ready must fall
            void'(hold_points.pop_front());
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
               stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      vertex_type v;
      int         burst;
      sb             = new();
      issued         = 0;
      send_idle_pct  = 0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.func       = FUNC_WRITE;
      req_bus.mat_row    = '0;
      req_bus.mat_col    = '0;
      req_bus.elem_value = '0;
      req_bus.vec_x      = '0;
      req_bus.vec_y      = '0;
      req_bus.vec_z      = '0;
      req_bus.vec_w      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: identity passthrough at the extremes, with junk in the element fields
      send_request(FUNC_XFORM, 2'd3, 2'd3, SAT_MIN,
                   make_vertex(ONE_VALUE, data_type'(-ONE_VALUE), SAT_MAX, SAT_MIN));
      send_xform(make_vertex('0, '0, '0, '0));
      // corner elements, then positive and negative saturation
      send_write(2'd0, 2'd0, SAT_MAX);
      send_write(2'd3, 2'd3, SAT_MIN);
      send_xform(make_vertex(SAT_MAX, data_type'(1), '0, SAT_MAX));
      send_xform(make_vertex(SAT_MIN, '0, '0, SAT_MIN));
      // smallest negative product must floor to -1, not round to zero
      send_write(2'd0, 2'd0, data_type'(1));
      send_xform(make_vertex(data_type'(-1), data_type'(1), '0, '0));
      // off-diagonal corners mixing x and w
      send_write(2'd0, 2'd3, ONE_VALUE);
      send_write(2'd3, 2'd0, data_type'(-ONE_VALUE));
      send_xform(rand_vertex());
      send_xform(make_vertex(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
      send_xform(make_vertex(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
      // back to identity, with a transform straight after the first write and after the last
      send_write(2'd0, 2'd0, ONE_VALUE);
      send_xform(rand_vertex());
      send_write(2'd3, 2'd3, ONE_VALUE);
      send_write(2'd0, 2'd3, '0);
      send_write(2'd3, 2'd0, '0);
      send_xform(rand_vertex());

      // random phase
      while (issued < ITEM_TARGET) begin
         case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            default: send_idle_pct = 40;
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // full matrix load then a stream of vertices through it
               for (int idx = 0; idx < MAT_DIM*MAT_DIM; idx++)
                  send_write(idx_type'(idx / MAT_DIM), idx_type'(idx % MAT_DIM), rand_elem());
               burst = $urandom_range(10, 50);
               repeat (burst) send_xform(rand_vertex());
            end
            3, 4, 5, 6, 7: begin
               // occasional element updates interleaved with transforms
               repeat (30) begin
                  if ($urandom_range(0, 4) == 0)
                     send_write(idx_type'($urandom()), idx_type'($urandom()), rand_elem());
                  else
                     send_xform(rand_vertex());
               end
            end
            default: begin
               // raw 32-bit noise in both elements and vectors
               repeat (10) begin
                  if ($urandom_range(0, 1) == 0) begin
                     send_write(idx_type'($urandom()), idx_type'($urandom()),
                                data_type'($urandom()));
                  end else begin
                     v = make_vertex(data_type'($urandom()), data_type'($urandom()),
                                     data_type'($urandom()), data_type'($urandom()));
                     send_xform(v);
                  end
               end
            end
         endcase
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;

      // drain, then give any stray response time to show
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4 * RESULT_LATENCY) @(posedge clock);

      $display("covered %0d requests: %0d matrix writes, %0d transforms, %0d saturated outputs",
               issued, sb.writes, sb.xforms, sb.saturations);
      $display("request side stalled for %0d cycles under response back-pressure",
               blocked_cycles);
      if (sb.errors == 0) begin
         $display("vertex_matrix_transform_tb: clean");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("vertex_matrix_transform_tb: errors");
      end
      $finish;
   end

endmodule

FILE: vertex_matrix_transform.f
hdl/vmt_pkg.sv
hdl/vmt_if.sv
hdl/vertex_matrix_transform.sv
hdl/vmt_checker.sv
dv/vertex_matrix_transform_tb.sv
